### design/dnfa_pkg.sv
`default_nettype none

package dnfa_pkg;

   localparam int MAX_LAYERS = 4;
   localparam int MAX_NODES  = 16;
   localparam int DATA_WIDTH = 16;

   localparam int FRAC_BITS = DATA_WIDTH / 2;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int LAYER_W   = $clog2(MAX_LAYERS);
   localparam int CNT_W     = NODE_W + 1;
   localparam int LCNT_W    = 3;
   localparam int PROD_W    = 2 * DATA_WIDTH;
   localparam int ACC_W     = 40;
   localparam int W_DEPTH   = (MAX_LAYERS - 1) * MAX_NODES * MAX_NODES;
   localparam int W_ADDR_W  = LAYER_W + 2 * NODE_W;
   localparam int A_DEPTH   = 2 * MAX_NODES;
   localparam int A_ADDR_W  = NODE_W + 1;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 5;

   // request kinds
   localparam logic REQ_WEIGHT  = 1'b0;
   localparam logic REQ_FEATURE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_NODES   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_HIDDEN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_HIDDEN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THIRD_HIDDEN  = 3'd4;

   typedef struct packed {
      logic                         req_type;
      logic [LAYER_W-1:0]           layer_select;
      logic [NODE_W-1:0]            dest_node;
      logic [NODE_W-1:0]            source_node;
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last;
   } req_payload_type;

   typedef struct packed {
      logic [NODE_W-1:0]            class_index;
      logic signed [DATA_WIDTH-1:0] best_score;
   } rsp_payload_type;

   typedef struct packed {
      logic [LCNT_W-1:0]                 layers;
      logic [MAX_LAYERS-1:0][CNT_W-1:0]  nodes;
   } cfg_type;

   // travels with each issued multiply-accumulate step
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic              final_layer;
      logic              out_half;
      logic [NODE_W-1:0] node;
   } mac_tag_type;

   typedef struct packed {
      logic                         we;
      logic [A_ADDR_W-1:0]          addr;
      logic signed [DATA_WIDTH-1:0] data;
   } act_wr_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ISSUE,
      SEQ_DRAIN,
      SEQ_DONE
   } seq_state_type;

   function automatic logic [CNT_W-1:0] clamp_nodes(input logic [CSR_W-1:0] raw);
      logic [CNT_W-1:0] r;
      r = CNT_W'(raw);
      if (raw == '0) begin
         r = CNT_W'(1);
      end else if (raw > CSR_W'(MAX_NODES)) begin
         r = CNT_W'(MAX_NODES);
      end
      return r;
   endfunction

   function automatic logic [LCNT_W-1:0] clamp_layers(input logic [LCNT_W-1:0] raw);
      logic [LCNT_W-1:0] r;
      r = raw;
      if (raw < LCNT_W'(2)) begin
         r = LCNT_W'(2);
      end else if (raw > LCNT_W'(MAX_LAYERS)) begin
         r = LCNT_W'(MAX_LAYERS);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### design/dnfa_seq.sv
`default_nettype none

module dnfa_seq
   import dnfa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                go,
   input  wire cfg_type             cfg,
   input  wire logic                pipe_busy,
   output mac_tag_type              issue_tag,
   output logic [W_ADDR_W-1:0]      w_raddr,
   output logic [A_ADDR_W-1:0]      a_raddr,
   output logic                     busy,
   output logic                     done
);

   seq_state_type      state_ff, state_in;
   logic [LAYER_W-1:0] layer_ff, layer_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [NODE_W-1:0]  src_ff, src_in;

   logic [CNT_W-1:0]   prev_n, cur_n;
   logic               last_src, last_node, final_layer;

   assign prev_n      = cfg.nodes[layer_ff - LAYER_W'(1)];
   assign cur_n       = cfg.nodes[layer_ff];
   assign last_src    = {1'b0, src_ff} == (prev_n - CNT_W'(1));
   assign last_node   = {1'b0, node_ff} == (cur_n - CNT_W'(1));
   assign final_layer = LCNT_W'(layer_ff) == (cfg.layers - LCNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         layer_ff <= LAYER_W'(1);
         node_ff  <= '0;
         src_ff   <= '0;
      end else begin
         state_ff <= state_in;
         layer_ff <= layer_in;
         node_ff  <= node_in;
         src_ff   <= src_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (go) state_in = SEQ_ISSUE;
         end
         SEQ_ISSUE: begin
            if (last_src && last_node) state_in = SEQ_DRAIN;
         end
         SEQ_DRAIN: begin
            // interlock: next layer reads what this one writes
            if (!pipe_busy) state_in = final_layer ? SEQ_DONE : SEQ_ISSUE;
         end
         SEQ_DONE: begin
            state_in = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // counters
   always_comb begin
      layer_in = layer_ff;
      node_in  = node_ff;
      src_in   = src_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (go) begin
               layer_in = LAYER_W'(1);
               node_in  = '0;
               src_in   = '0;
            end
         end
         SEQ_ISSUE: begin
            if (last_src) begin
               src_in  = '0;
               node_in = last_node ? '0 : node_ff + NODE_W'(1);
            end else begin
               src_in = src_ff + NODE_W'(1);
            end
         end
         SEQ_DRAIN: begin
            if (!pipe_busy && !final_layer) layer_in = layer_ff + LAYER_W'(1);
         end
         default: begin
            layer_in = layer_ff;
         end
      endcase
   end

   // outputs
   always_comb begin
      issue_tag.valid       = 1'b0;
      issue_tag.first       = src_ff == '0;
      issue_tag.last        = last_src;
      issue_tag.final_layer = final_layer;
      issue_tag.out_half    = layer_ff[0];
      issue_tag.node        = node_ff;
      busy                  = 1'b1;
      done                  = 1'b0;
      case (state_ff)
         SEQ_IDLE:  busy            = 1'b0;
         SEQ_ISSUE: issue_tag.valid = 1'b1;
         SEQ_DONE:  done            = 1'b1;
         default:   busy            = 1'b1;
      endcase
   end

   assign w_raddr = {layer_ff - LAYER_W'(1), node_ff, src_ff};
   assign a_raddr = {~layer_ff[0], src_ff};

endmodule

`default_nettype wire

### design/dnfa_mac.sv
`default_nettype none

module dnfa_mac
   import dnfa_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mac_tag_type                  issue_tag,
   input  wire logic signed [DATA_WIDTH-1:0] w_rdata,
   input  wire logic signed [DATA_WIDTH-1:0] a_rdata,
   output act_wr_type                        act_wr,
   output logic                              pipe_busy,
   output logic [NODE_W-1:0]                 best_index,
   output logic signed [DATA_WIDTH-1:0]      best_score
);

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (DATA_WIDTH - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   mac_tag_type                  st1_ff, st2_ff, st3_ff;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in, shifted;
   logic signed [DATA_WIDTH-1:0] sat;
   logic signed [DATA_WIDTH-1:0] best_ff;
   logic [NODE_W-1:0]            best_idx_ff;
   logic                         take_best;

   assign prod_in = w_rdata * a_rdata;
   assign acc_in  = (st2_ff.first ? '0 : acc_ff)
                  + {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // floor shift, then clip to Q8.8
   assign shifted = acc_ff >>> FRAC_BITS;
   always_comb begin
      if (shifted > SAT_HI) begin
         sat = SAT_HI[DATA_WIDTH-1:0];
      end else if (shifted < SAT_LO) begin
         sat = SAT_LO[DATA_WIDTH-1:0];
      end else begin
         sat = shifted[DATA_WIDTH-1:0];
      end
   end

   assign take_best = st3_ff.valid && st3_ff.last && st3_ff.final_layer
                      && ((st3_ff.node == '0) || (sat > best_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff <= '0;
         st2_ff <= '0;
         st3_ff <= '0;
         acc_ff <= '0;
      end else begin
         st1_ff <= issue_tag;
         st2_ff <= st1_ff;
         st3_ff <= st2_ff;
         if (st2_ff.valid) acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (take_best) begin
         best_ff     <= sat;
         best_idx_ff <= st3_ff.node;
      end
   end

   assign act_wr.we   = st3_ff.valid && st3_ff.last;
   assign act_wr.addr = {st3_ff.out_half, st3_ff.node};
   assign act_wr.data = sat;

   assign pipe_busy  = st1_ff.valid || st2_ff.valid || st3_ff.valid;
   assign best_index = best_idx_ff;
   assign best_score = best_ff;

endmodule

`default_nettype wire

### design/dense_network_forward_argmax.sv
// Channel    Ports                                   Direction  Handshake
// request    start, busy, req_payload                in         start && !busy
// result     rsp_valid, rsp_payload                  out        one-cycle strobe
// config     csr_write_en, csr_index, csr_wdata      in         write enable
//
// While no pass runs, a weight or feature load is taken every cycle.
// A feature marked last starts the pass: each layer issues prev_nodes * nodes
// multiply-accumulate steps on the single multiply-accumulate unit, then drains the
// weight/activation read, multiply and accumulate stages before the next layer.
// Reset is synchronous; memories are not cleared. The result strobe cannot be stalled.
`default_nettype none

module dense_network_forward_argmax
   import dnfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   logic [LCNT_W-1:0]                 layer_count_ff;
   logic [MAX_LAYERS-1:0][CSR_W-1:0]  node_cfg_ff;
   cfg_type                           cfg;

   logic signed [DATA_WIDTH-1:0] weight_mem [W_DEPTH];
   logic signed [DATA_WIDTH-1:0] act_mem [A_DEPTH];
   logic signed [DATA_WIDTH-1:0] w_rdata_ff, a_rdata_ff;

   logic                 accept, w_we, go, pipe_busy;
   logic [W_ADDR_W-1:0]  w_waddr, w_raddr;
   logic [A_ADDR_W-1:0]  a_raddr, a_waddr;
   logic signed [DATA_WIDTH-1:0] a_wdata;
   logic                 a_we;
   mac_tag_type          issue_tag;
   act_wr_type           act_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= LCNT_W'(2);
         node_cfg_ff    <= {MAX_LAYERS{CSR_W'(MAX_NODES)}};
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_LAYER_COUNT:   layer_count_ff <= csr_wdata[LCNT_W-1:0];
            CSR_INPUT_NODES:   node_cfg_ff[0] <= csr_wdata;
            CSR_FIRST_HIDDEN:  node_cfg_ff[1] <= csr_wdata;
            CSR_SECOND_HIDDEN: node_cfg_ff[2] <= csr_wdata;
            CSR_THIRD_HIDDEN:  node_cfg_ff[3] <= csr_wdata;
            default:           layer_count_ff <= layer_count_ff;
         endcase
      end
   end

   always_comb begin
      cfg.layers = clamp_layers(layer_count_ff);
      for (int i = 0; i < MAX_LAYERS; i++) begin
         cfg.nodes[i] = clamp_nodes(node_cfg_ff[i]);
      end
   end

   assign accept  = start && !busy;
   assign w_we    = accept && (req_payload.req_type == REQ_WEIGHT)
                    && (req_payload.layer_select != '0);
   assign w_waddr = {req_payload.layer_select - LAYER_W'(1),
                     req_payload.dest_node, req_payload.source_node};
   assign go      = accept && (req_payload.req_type == REQ_FEATURE) && req_payload.last;

   // features land in the low half; layer results own the port during a pass
   always_comb begin
      if (act_wr.we) begin
         a_we    = 1'b1;
         a_waddr = act_wr.addr;
         a_wdata = act_wr.data;
      end else begin
         a_we    = accept && (req_payload.req_type == REQ_FEATURE);
         a_waddr = {1'b0, req_payload.source_node};
         a_wdata = req_payload.value;
      end
   end

   always_ff @(posedge clock) begin
      if (w_we) weight_mem[w_waddr] <= req_payload.value;
      w_rdata_ff <= weight_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (a_we) act_mem[a_waddr] <= a_wdata;
      a_rdata_ff <= act_mem[a_raddr];
   end

   dnfa_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .cfg       (cfg),
      .pipe_busy (pipe_busy),
      .issue_tag (issue_tag),
      .w_raddr   (w_raddr),
      .a_raddr   (a_raddr),
      .busy      (busy),
      .done      (rsp_valid)
   );

   dnfa_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .issue_tag  (issue_tag),
      .w_rdata    (w_rdata_ff),
      .a_rdata    (a_rdata_ff),
      .act_wr     (act_wr),
      .pipe_busy  (pipe_busy),
      .best_index (rsp_payload.class_index),
      .best_score (rsp_payload.best_score)
   );

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_rsp_drained : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !pipe_busy)
      else $error("result given while the datapath still holds work");

   a_busy_ends_with_rsp : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid))
      else $error("pass ended without a result");

   a_no_load_in_pass : assert property (@(posedge clock) disable iff (reset)
      act_wr.we |-> busy)
      else $error("layer write outside a pass");

endmodule

`default_nettype wire

### sim/dnfa_score_checker.sv
`timescale 1ns / 1ps

module dnfa_score_checker
   import dnfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata,
   output int                    mismatches,
   output int                    outstanding,
   output int                    scores_checked
);

   localparam longint Q_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
   localparam longint Q_MIN = -Q_MAX - 1;

   logic signed [DATA_WIDTH-1:0] weight_mem [MAX_LAYERS-1][MAX_NODES][MAX_NODES];
   logic signed [DATA_WIDTH-1:0] act_buf [A_DEPTH];
   logic [LCNT_W-1:0]            layer_reg;
   logic [CSR_W-1:0]             node_reg [MAX_LAYERS];
   rsp_payload_type              expected_scores [$];

   initial begin
      mismatches     = 0;
      scores_checked = 0;
      outstanding    = 0;
   end

   function automatic int node_limit(input logic [CSR_W-1:0] raw);
      if (raw == '0) begin
         return 1;
      end else if (raw > CSR_W'(MAX_NODES)) begin
         return MAX_NODES;
      end
      return int'(raw);
   endfunction

   // Q16.16 sum -> Q8.8, floor then saturate
   function automatic logic signed [DATA_WIDTH-1:0] to_q88(input longint acc);
      longint q;
      q = acc >>> FRAC_BITS;
      if (q > Q_MAX) begin
         q = Q_MAX;
      end else if (q < Q_MIN) begin
         q = Q_MIN;
      end
      return q[DATA_WIDTH-1:0];
   endfunction

   // runs every configured layer over the ping-pong buffer, then picks the top score
   function automatic rsp_payload_type forward_pass();
      int                           n_layers, prev_n, cur_n, in_base, out_base, best_i;
      longint                       acc;
      logic signed [DATA_WIDTH-1:0] best;
      rsp_payload_type              r;
      n_layers = int'(layer_reg);
      if (n_layers < 2) begin
         n_layers = 2;
      end else if (n_layers > MAX_LAYERS) begin
         n_layers = MAX_LAYERS;
      end
      prev_n  = node_limit(node_reg[0]);
      cur_n   = prev_n;
      in_base = 0;
      for (int l = 1; l < n_layers; l++) begin
         cur_n    = node_limit(node_reg[l]);
         out_base = MAX_NODES - in_base;
         for (int n = 0; n < cur_n; n++) begin
            acc = 0;
            for (int k = 0; k < prev_n; k++) begin
               acc += longint'(weight_mem[l-1][n][k]) * longint'(act_buf[in_base+k]);
            end
            act_buf[out_base+n] = to_q88(acc);
         end
         in_base = out_base;
         prev_n  = cur_n;
      end
      best   = act_buf[in_base];
      best_i = 0;
      for (int n = 1; n < cur_n; n++) begin
         if (act_buf[in_base+n] > best) begin
            best   = act_buf[in_base+n];
            best_i = n;
         end
      end
      r.class_index = NODE_W'(best_i);
      r.best_score  = best;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         layer_reg = LCNT_W'(2);
         for (int i = 0; i < MAX_LAYERS; i++) begin
            node_reg[i] = CSR_W'(MAX_NODES);
         end
         expected_scores.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_LAYER_COUNT:   layer_reg   = csr_wdata[LCNT_W-1:0];
               CSR_INPUT_NODES:   node_reg[0] = csr_wdata;
               CSR_FIRST_HIDDEN:  node_reg[1] = csr_wdata;
               CSR_SECOND_HIDDEN: node_reg[2] = csr_wdata;
               CSR_THIRD_HIDDEN:  node_reg[3] = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid) begin
            if (expected_scores.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected result: class %0d score %0d",
                           rsp_payload.class_index, $signed(rsp_payload.best_score));
               end
               mismatches++;
            end else begin
               want = expected_scores.pop_front();
               scores_checked++;
               if (rsp_payload.class_index !== want.class_index ||
                   rsp_payload.best_score !== want.best_score) begin
                  if (mismatches < 10) begin
                     $display("result %0d: expected class %0d score %0d, got %0d score %0d",
                              scores_checked, want.class_index, $signed(want.best_score),
                              rsp_payload.class_index, $signed(rsp_payload.best_score));
                  end
                  mismatches++;
               end
            end
         end

         if (start && !busy) begin
            if (req_payload.req_type == REQ_WEIGHT) begin
               // layer select zero is dropped
               if (req_payload.layer_select != '0) begin
                  weight_mem[int'(req_payload.layer_select) - 1][req_payload.dest_node]
                            [req_payload.source_node] = req_payload.value;
               end
            end else begin
               act_buf[int'(req_payload.source_node)] = req_payload.value;
               if (req_payload.last) begin
                  expected_scores.insert(expected_scores.size(), forward_pass());
               end
            end
         end
      end
      outstanding <= expected_scores.size();
   end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import dnfa_pkg::*;

   localparam int ITEM_TARGET = 1625;
   localparam int DRAIN_LIMIT = 4000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_BASE = CSR_THIRD_HIDDEN + 1'b1;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_payload_type      req_payload;
   logic                 rsp_valid;
   rsp_payload_type      rsp_payload;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   mismatches;
   int                   outstanding;
   int                   scores_checked;

   // what the stimulus knows: active shape and which entries hold data
   int                   net_layers;
   int                   net_nodes [MAX_LAYERS];
   bit                   weight_seen [MAX_LAYERS-1][MAX_NODES][MAX_NODES];
   bit [MAX_NODES-1:0]   feature_seen;
   bit                   bursty;
   int                   burst_left;
   int                   items_sent = 0;
   int                   passes = 0;
   int                   settings = 0;

   dense_network_forward_argmax dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   dnfa_score_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .scores_checked (scores_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // mostly small magnitudes so sums stay in range, with rails and full-range values mixed in
   function automatic logic signed [DATA_WIDTH-1:0] rand_value();
      logic signed [DATA_WIDTH-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = 16'sh7FFF;
         1:       v = 16'sh8000;
         2, 3:    v = DATA_WIDTH'($urandom);
         default: v = DATA_WIDTH'(int'($urandom_range(0, 768)) - 384);
      endcase
      return v;
   endfunction

   function automatic int rand_nodes();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return MAX_NODES;
      end else if (pick == 1) begin
         return 1;
      end else if (pick < 4) begin
         return $urandom_range(1, MAX_NODES);
      end
      return $urandom_range(1, 6);
   endfunction

   function automatic req_payload_type weight_item(input int layer, input int dest,
                                                   input int src,
                                                   input logic signed [DATA_WIDTH-1:0] v,
                                                   input bit last_flag);
      req_payload_type p;
      p.req_type     = REQ_WEIGHT;
      p.layer_select = LAYER_W'(layer);
      p.dest_node    = NODE_W'(dest);
      p.source_node  = NODE_W'(src);
      p.value        = v;
      p.last         = last_flag;
      return p;
   endfunction

   // layer_select and dest_node mean nothing on a feature; keep them random
   function automatic req_payload_type feature_item(input int src,
                                                    input logic signed [DATA_WIDTH-1:0] v,
                                                    input bit last_flag);
      req_payload_type p;
      p.req_type     = REQ_FEATURE;
      p.layer_select = LAYER_W'($urandom);
      p.dest_node    = NODE_W'($urandom);
      p.source_node  = NODE_W'(src);
      p.value        = v;
      p.last         = last_flag;
      return p;
   endfunction

   task automatic issue(input req_payload_type p);
      if (bursty && burst_left <= 0) begin
         start <= 1'b0;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 8))
            @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      start       <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
      items_sent++;
      if (p.req_type == REQ_WEIGHT) begin
         if (p.layer_select != '0) begin
            weight_seen[int'(p.layer_select) - 1][p.dest_node][p.source_node] = 1'b1;
         end
      end else begin
         feature_seen[p.source_node] = 1'b1;
         if (p.last) begin
            passes++;
            // a four-layer pass leaves layer two in the feature half
            if (net_layers == MAX_LAYERS) begin
               for (int k = 0; k < net_nodes[2]; k++) feature_seen[k] = 1'b1;
            end
         end
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   // effective shape in, register codes out; aliases exercise out-of-range codes
   task automatic configure(input int layers, input int n0, input int n1, input int n2,
                            input int n3);
      logic [CSR_W-1:0] raw [MAX_LAYERS];
      int               code;
      net_layers   = layers;
      net_nodes[0] = n0;
      net_nodes[1] = n1;
      net_nodes[2] = n2;
      net_nodes[3] = n3;
      for (int i = 0; i < MAX_LAYERS; i++) begin
         code = net_nodes[i];
         if (code == 1) begin
            code = $urandom_range(0, 1);
         end else if (code == MAX_NODES) begin
            code = $urandom_range(MAX_NODES, 2 * MAX_NODES - 1);
         end
         raw[i] = CSR_W'(code);
      end
      code = layers;
      if (layers == 2) begin
         code = $urandom_range(0, 2);
      end else if (layers == MAX_LAYERS) begin
         code = $urandom_range(MAX_LAYERS, 7);
      end
      // upper bits of the layer count field are don't-care
      csr_write(CSR_LAYER_COUNT, CSR_W'(($urandom_range(0, 3) << LCNT_W) | code));
      csr_write(CSR_INPUT_NODES, raw[0]);
      csr_write(CSR_FIRST_HIDDEN, raw[1]);
      csr_write(CSR_SECOND_HIDDEN, raw[2]);
      csr_write(CSR_THIRD_HIDDEN, raw[3]);
      if ($urandom_range(0, 3) == 0) begin
         csr_write(CSR_SPARE_BASE + CSR_IDX_W'($urandom_range(0, 2)), CSR_W'($urandom));
      end
      csr_write_en <= 1'b0;
      settings++;
   endtask

   task automatic fill_weights();
      for (int l = 1; l < net_layers; l++) begin
         for (int n = 0; n < net_nodes[l]; n++) begin
            for (int k = 0; k < net_nodes[l-1]; k++) begin
               if (!weight_seen[l-1][n][k]) begin
                  issue(weight_item(l, n, k, rand_value(), $urandom_range(0, 15) == 0));
               end
            end
         end
      end
   endtask

   task automatic run_pass();
      int l, last_src, offset, k;
      bit refresh;
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 5))
            0: issue(weight_item($urandom_range(0, MAX_LAYERS - 1), $urandom_range(0, 15),
                                 $urandom_range(0, 15), rand_value(), $urandom_range(0, 1)));
            1: issue(feature_item($urandom_range(0, MAX_NODES - 1), rand_value(), 1'b0));
            default: begin
               l = $urandom_range(1, net_layers - 1);
               issue(weight_item(l, $urandom_range(0, net_nodes[l] - 1),
                                 $urandom_range(0, net_nodes[l-1] - 1), rand_value(), 1'b0));
            end
         endcase
      end
      last_src = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_NODES - 1)
                                             : $urandom_range(0, net_nodes[0] - 1);
      // without refresh, stale features (possibly layer-two output) are reused
      refresh  = $urandom_range(0, 2) != 0;
      offset   = $urandom_range(0, net_nodes[0] - 1);
      for (int j = 0; j < net_nodes[0]; j++) begin
         k = (offset + j) % net_nodes[0];
         if (k != last_src && (refresh || !feature_seen[k])) begin
            issue(feature_item(k, rand_value(), 1'b0));
         end
      end
      issue(feature_item(last_src, rand_value(), 1'b1));
   endtask

   initial begin
      int waited;
      reset        = 1'b1;
      start        = 1'b0;
      req_payload  = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      feature_seen = '0;
      bursty       = 1'b0;
      burst_left   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // saturation both ways, floor rounding, ties, ignored writes
      configure(2, 2, 3, 1, 1);
      issue(weight_item(1, 0, 0, 16'sh7FFF, 1'b0));
      issue(weight_item(1, 0, 1, 16'sh7FFF, 1'b0));
      issue(weight_item(1, 1, 0, 16'sh8000, 1'b0));
      issue(weight_item(1, 1, 1, 16'sh7FFF, 1'b0));
      issue(weight_item(1, 2, 0, 16'sh0001, 1'b0));
      issue(weight_item(1, 2, 1, 16'shFFFF, 1'b0));
      issue(feature_item(0, 16'sh7FFF, 1'b0));
      issue(feature_item(1, 16'sh7FFF, 1'b1));
      issue(weight_item(0, 15, 15, 16'sh1234, 1'b0));
      issue(weight_item(1, 0, 0, 16'sh8000, 1'b1));
      issue(feature_item(15, 16'sh8000, 1'b0));
      issue(feature_item(0, 16'shFFFF, 1'b0));
      issue(feature_item(1, 16'sh0001, 1'b1));
      issue(weight_item(1, 2, 0, 16'sh7FFF, 1'b0));
      issue(weight_item(1, 2, 1, 16'sh7FFF, 1'b0));
      issue(feature_item(1, 16'sh8000, 1'b1));
      drain();
      configure(4, 1, 1, 1, 1);
      fill_weights();
      issue(feature_item(0, 16'sh7FFF, 1'b1));

      // largest network once
      drain();
      configure(4, MAX_NODES, MAX_NODES, MAX_NODES, MAX_NODES);
      bursty = 1'b1;
      fill_weights();
      run_pass();
      run_pass();

      while (items_sent < ITEM_TARGET) begin
         drain();
         configure($urandom_range(2, MAX_LAYERS), rand_nodes(), rand_nodes(), rand_nodes(),
                   rand_nodes());
         bursty = $urandom_range(0, 3) != 0;
         fill_weights();
         repeat ($urandom_range(3, 12)) begin
            run_pass();
            if ($urandom_range(0, 9) == 0) drain();
         end
      end

      start <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);

      $display("%0d transactions, %0d forward passes, %0d scores checked, %0d register settings",
               items_sent, passes, scores_checked, settings);
      $display("shapes of 2..4 layers, 1..16 nodes; saturation, ties, reused features covered");
      if (outstanding != 0) $display("%0d expected scores never arrived", outstanding);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### files.f
design/dnfa_pkg.sv
design/dnfa_seq.sv
design/dnfa_mac.sv
design/dense_network_forward_argmax.sv
sim/dnfa_score_checker.sv
sim/tb_top.sv
